// ===== rtl/core/smlr_pkg.sv =====
// Shared widths, constants and register codes for the stereo mix resampler.
package smlr_pkg;

  // Field widths
  localparam int IN_W   = 18;
  localparam int MIX_W  = 19;
  localparam int OUT_W  = 16;
  localparam int CNT_W  = 32;
  localparam int STEP_W = 18;

  // Stream payload widths (packed fields padded to whole bytes)
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  // APB port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register word index taken from paddr[2]
  typedef enum logic {
    REG_STEP_RATIO = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_e;

  // Reset value of step_ratio
  localparam logic [STEP_W-1:0] STEP_RESET = 18'd82560;

  // Output saturation limits
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

endpackage

// ===== rtl/core/smlr_cfg.sv =====
// APB register block holding the step_ratio register.
module smlr_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [smlr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [smlr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [smlr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [smlr_pkg::STEP_W-1:0]          step_o
);

  logic [smlr_pkg::STEP_W-1:0] step_q;
  logic                        step_sel;
  logic                        wr_en;

  assign pready   = 1'b1;
  assign step_sel = (smlr_pkg::reg_idx_e'(paddr[2]) == smlr_pkg::REG_STEP_RATIO);
  assign wr_en    = psel && penable && pwrite && pready && step_sel;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= smlr_pkg::STEP_RESET;
    end else if (wr_en) begin
      step_q <= pwdata[smlr_pkg::STEP_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (step_sel) begin
      prdata = smlr_pkg::APB_DATA_W'(step_q);
    end
  end

  assign step_o = step_q;

endmodule

// ===== rtl/core/smlr_phase.sv =====
// Output phase accumulator: emit decision and interpolation fraction.
module smlr_phase #(
  parameter int FRAC_W = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [smlr_pkg::STEP_W-1:0]  step_i,
  output logic                         emit_o,
  output logic [FRAC_W:0]              frac_o
);

  localparam int OW = FRAC_W + 4;
  localparam int WW = ((OW > smlr_pkg::STEP_W) ? OW : smlr_pkg::STEP_W) + 2;

  localparam logic signed [WW-1:0] ONE_W  = WW'(1) <<< FRAC_W;
  localparam logic signed [WW-1:0] MAX_W  = (WW'(1) <<< (OW - 1)) - WW'(1);
  localparam logic signed [WW-1:0] MIN_W  = -(WW'(1) <<< (OW - 1));
  localparam logic signed [OW-1:0] OFS_RST = OW'(-ONE_W);

  // Clamp a wide value into the offset range
  function automatic logic signed [OW-1:0] sat_ofs(input logic signed [WW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > MAX_W) begin
      r = OW'(MAX_W);
    end else if (v < MIN_W) begin
      r = OW'(MIN_W);
    end else begin
      r = OW'(v);
    end
    return r;
  endfunction

  // Offset already lowered by one input sample, ready for the next item
  logic signed [OW-1:0] ofs_q, ofs_d;
  logic signed [WW-1:0] ofs_w;
  logic signed [WW-1:0] step_w;
  logic signed [WW-1:0] frac_w;
  logic signed [OW-1:0] base;

  assign ofs_w  = WW'(ofs_q);
  assign step_w = signed'(WW'(step_i));
  assign emit_o = ofs_q[OW-1] || (ofs_q == '0);

  // Fraction = offset + 1.0, clamped at zero
  assign frac_w = ofs_w + ONE_W;
  assign frac_o = frac_w[WW-1] ? '0 : frac_w[FRAC_W:0];

  // Next offset: advance by the step on emit, then lower by one
  always_comb begin
    base  = emit_o ? sat_ofs(ofs_w + step_w) : ofs_q;
    ofs_d = sat_ofs(WW'(base) - ONE_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= OFS_RST;
    end else if (advance_i) begin
      ofs_q <= ofs_d;
    end
  end

endmodule

// ===== rtl/core/smlr_interp.sv =====
// One channel of linear interpolation with 16-bit saturation.
module smlr_interp #(
  parameter int FRAC_W = 16
) (
  input  logic signed [smlr_pkg::MIX_W-1:0] prev_i,
  input  logic signed [smlr_pkg::MIX_W-1:0] cur_i,
  input  logic        [FRAC_W:0]            frac_i,
  output logic        [smlr_pkg::OUT_W-1:0] out_o,
  output logic                              clip_o
);

  localparam int DW = smlr_pkg::MIX_W + 1;
  localparam int PW = DW + FRAC_W + 2;
  localparam int SW = smlr_pkg::MIX_W + 4;

  localparam logic signed [SW-1:0] SAT_HI = SW'(smlr_pkg::OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(smlr_pkg::OUT_MIN);

  logic signed [DW-1:0]        diff;
  logic signed [FRAC_W+1:0]    frac_s;
  logic signed [PW-1:0]        prod;
  logic        [PW-1:0]        bias;
  logic        [PW-1:0]        biased;
  logic signed [PW-FRAC_W-1:0] quot;
  logic signed [SW-1:0]        sum;

  // Delta times fraction
  assign diff   = DW'(cur_i) - DW'(prev_i);
  assign frac_s = {1'b0, frac_i};
  assign prod   = diff * frac_s;

  // Divide by 2^FRAC_W, truncating toward zero
  assign bias   = prod[PW-1] ? PW'({FRAC_W{1'b1}}) : '0;
  assign biased = prod + bias;
  assign quot   = biased[PW-1:FRAC_W];

  assign sum = SW'(prev_i) + SW'(quot);

  // Saturate to 16 bits
  always_comb begin
    clip_o = 1'b0;
    out_o  = sum[smlr_pkg::OUT_W-1:0];
    if (sum > SAT_HI) begin
      clip_o = 1'b1;
      out_o  = SAT_HI[smlr_pkg::OUT_W-1:0];
    end else if (sum < SAT_LO) begin
      clip_o = 1'b1;
      out_o  = SAT_LO[smlr_pkg::OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/core/stereo_mix_linear_resampler.sv =====
// Top level: stereo mix, linear-interpolating resampler and clip counter.
//
//  Port group   Dir  Payload
//  s_axis_*     in   tdata: left_in[17:0], right_in[35:18], mono_in[53:36]
//  m_axis_*     out  tdata: left_out[15:0], right_out[31:16], left_clipped[32],
//                          right_clipped[33], clip_total[65:34]
//  APB          in   step_ratio at byte address 0
//
//  One item per cycle sustained while the output is not stalled; an input
//  transaction is registered in the input register, then its result is loaded
//  into the result register, from which it can be taken.
//  Items that produce no sample only update the previous mix and the phase.
//  A stalled result register holds the input stage; the input register
//  still takes a new item in the cycle the result is taken.
//  Reset clears the phase, previous mixes and clip counter, and loads the
//  default step_ratio.
module stereo_mix_linear_resampler #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [smlr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // left_in, right_in, mono_in
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [smlr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // left_out, right_out,
                                                             // left_clipped, right_clipped,
                                                             // clip_total
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smlr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [smlr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [smlr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IN_W  = smlr_pkg::IN_W;
  localparam int MIX_W = smlr_pkg::MIX_W;
  localparam int OUT_W = smlr_pkg::OUT_W;
  localparam int CNT_W = smlr_pkg::CNT_W;

  logic [smlr_pkg::STEP_W-1:0] step;

  smlr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .step_o  (step)
  );

  // Input decode and mix: in + mono/2 (toward zero)
  logic [IN_W-1:0]         l_in, r_in, m_in;
  logic [IN_W:0]           mono_e;
  logic [IN_W-1:0]         half;
  logic signed [MIX_W-1:0] lmix_d, rmix_d;

  assign l_in   = s_axis_tdata[IN_W-1:0];
  assign r_in   = s_axis_tdata[2*IN_W-1:IN_W];
  assign m_in   = s_axis_tdata[3*IN_W-1:2*IN_W];
  assign mono_e = {m_in[IN_W-1], m_in} + {{IN_W{1'b0}}, m_in[IN_W-1]};
  assign half   = mono_e[IN_W:1];
  assign lmix_d = {l_in[IN_W-1], l_in} + {half[IN_W-1], half};
  assign rmix_d = {r_in[IN_W-1], r_in} + {half[IN_W-1], half};

  // Input register
  logic                    in_vld_q;
  logic signed [MIX_W-1:0] lmix_q, rmix_q;
  logic                    in_take;
  logic                    adv;
  logic                    out_vld_q;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      lmix_q <= lmix_d;
      rmix_q <= rmix_d;
    end
  end

  // Phase accumulator
  logic                     emit;
  logic [PHASE_FRAC_BITS:0] frac;

  smlr_phase #(
    .FRAC_W (PHASE_FRAC_BITS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (adv),
    .step_i    (step),
    .emit_o    (emit),
    .frac_o    (frac)
  );

  // Previous mix
  logic signed [MIX_W-1:0] prev_l_q, prev_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else if (adv) begin
      prev_l_q <= lmix_q;
      prev_r_q <= rmix_q;
    end
  end

  // Interpolation, one unit per channel
  logic [OUT_W-1:0] l_out, r_out;
  logic             l_clip, r_clip;

  smlr_interp #(
    .FRAC_W (PHASE_FRAC_BITS)
  ) u_interp_l (
    .prev_i (prev_l_q),
    .cur_i  (lmix_q),
    .frac_i (frac),
    .out_o  (l_out),
    .clip_o (l_clip)
  );

  smlr_interp #(
    .FRAC_W (PHASE_FRAC_BITS)
  ) u_interp_r (
    .prev_i (prev_r_q),
    .cur_i  (rmix_q),
    .frac_i (frac),
    .out_o  (r_out),
    .clip_o (r_clip)
  );

  // Clip counter
  logic             out_load;
  logic [CNT_W-1:0] clip_q, clip_d;

  assign out_load = adv && emit;
  assign clip_d   = clip_q + CNT_W'(l_clip) + CNT_W'(r_clip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
    end else if (out_load) begin
      clip_q <= clip_d;
    end
  end

  // Result register
  logic [OUT_W-1:0] l_out_q, r_out_q;
  logic             l_clip_q, r_clip_q;
  logic [CNT_W-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      l_out_q  <= l_out;
      r_out_q  <= r_out;
      l_clip_q <= l_clip;
      r_clip_q <= r_clip;
      total_q  <= clip_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, total_q, r_clip_q, l_clip_q, r_out_q, l_out_q};

endmodule

// ===== bench/stereo_resample_checker.sv =====
// Checker: predicts the resampler's stereo output transactions and compares them.
`timescale 1ns / 1ps
module stereo_resample_checker #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream, observed
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [smlr_pkg::IN_TDATA_W-1:0]   s_tdata_i,   // left_in, right_in, mono_in
  // Output stream, observed
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [smlr_pkg::OUT_TDATA_W-1:0]  m_tdata_i,   // left_out, right_out, left_clipped,
                                                         // right_clipped, clip_total
  // Register port, observed
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic                              pready_i,
  input  logic [smlr_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [smlr_pkg::APB_DATA_W-1:0]   pwdata_i,
  input  logic [smlr_pkg::APB_DATA_W-1:0]   prdata_i,
  // Status to the bench top
  output int unsigned                       mismatches_o,
  output int unsigned                       pending_o
);
  import smlr_pkg::*;

  localparam int     PHASE_W   = PHASE_FRAC_BITS + 4;
  localparam longint UNIT      = longint'(1) << PHASE_FRAC_BITS;
  localparam longint PHASE_MAX = (longint'(1) << (PHASE_W - 1)) - 1;
  localparam longint PHASE_MIN = -(longint'(1) << (PHASE_W - 1));

  typedef struct {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    left_clip;
    logic                    right_clip;
    logic [CNT_W-1:0]        clip_total;
  } stereo_frame_t;

  // Frames owed by the block, oldest first
  stereo_frame_t             frames_due[$];

  // Predicted block state
  logic [STEP_W-1:0]         step_ratio_q;
  logic signed [MIX_W-1:0]   last_left_mix;
  logic signed [MIX_W-1:0]   last_right_mix;
  logic signed [PHASE_W-1:0] phase_ofs;
  logic [CNT_W-1:0]          clip_count;

  initial mismatches_o = 0;

  function automatic longint clamp_phase(input longint v);
    if (v > PHASE_MAX) return PHASE_MAX;
    if (v < PHASE_MIN) return PHASE_MIN;
    return v;
  endfunction

  // Step from the previous mix toward the new one; saturate to 16 bits
  function automatic logic signed [OUT_W-1:0] blend(input longint prev, input longint cur,
                                                    input longint frac, output logic clipped);
    longint v;
    v = prev + ((cur - prev) * frac) / UNIT;  // signed divide truncates toward zero
    clipped = (v > OUT_MAX) || (v < OUT_MIN);
    if (v > OUT_MAX) v = OUT_MAX;
    else if (v < OUT_MIN) v = OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endfunction

  // Mix one engine sample, advance the phase, queue a frame when one falls due
  task automatic predict_sample(input logic [IN_TDATA_W-1:0] word);
    logic signed [IN_W-1:0] l_in;
    logic signed [IN_W-1:0] r_in;
    logic signed [IN_W-1:0] m_in;
    longint                 half_mono;
    longint                 l_mix;
    longint                 r_mix;
    longint                 ofs;
    longint                 frac;
    stereo_frame_t          f;
    l_in = word[IN_W-1:0];
    r_in = word[2*IN_W-1:IN_W];
    m_in = word[3*IN_W-1:2*IN_W];
    half_mono = longint'(m_in) / 2;
    l_mix = longint'(l_in) + half_mono;
    r_mix = longint'(r_in) + half_mono;
    ofs = clamp_phase(longint'(phase_ofs) - UNIT);
    if (ofs <= 0) begin
      frac = ofs + UNIT;
      if (frac < 0) frac = 0;
      f.left  = blend(longint'(last_left_mix), l_mix, frac, f.left_clip);
      f.right = blend(longint'(last_right_mix), r_mix, frac, f.right_clip);
      clip_count = clip_count + f.left_clip + f.right_clip;
      f.clip_total = clip_count;
      frames_due.push_back(f);
      ofs = clamp_phase(ofs + longint'(step_ratio_q));
    end
    phase_ofs      = ofs[PHASE_W-1:0];
    last_left_mix  = l_mix[MIX_W-1:0];
    last_right_mix = r_mix[MIX_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_frame_t want;
    if (!rst_ni) begin
      frames_due.delete();
      step_ratio_q   = STEP_RESET;
      last_left_mix  = '0;
      last_right_mix = '0;
      phase_ofs      = '0;
      clip_count     = '0;
    end else begin
      // Output transaction against the oldest frame owed
      if (m_tvalid_i && m_tready_i) begin
        if (frames_due.size() == 0) begin
          $error("output transaction with no frame due");
          mismatches_o++;
        end else begin
          want = frames_due.pop_front();
          check_field("left_out", want.left, $signed(m_tdata_i[OUT_W-1:0]));
          check_field("right_out", want.right, $signed(m_tdata_i[2*OUT_W-1:OUT_W]));
          check_field("left_clipped", want.left_clip, m_tdata_i[2*OUT_W]);
          check_field("right_clipped", want.right_clip, m_tdata_i[2*OUT_W+1]);
          check_field("clip_total", want.clip_total,
                      m_tdata_i[2*OUT_W+2+CNT_W-1:2*OUT_W+2]);
        end
      end
      // Input transaction
      if (s_tvalid_i && s_tready_i) predict_sample(s_tdata_i);
      // Register access; the unmapped word is ignored
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_STEP_RATIO) begin
        if (pwrite_i) step_ratio_q = pwdata_i[STEP_W-1:0];
        else check_field("step_ratio", longint'(step_ratio_q), longint'(prdata_i));
      end
    end
    pending_o = frames_due.size();
  end

endmodule

// ===== bench/stereo_mix_linear_resampler_test.sv =====
// Bench top: drives the stereo mix resampler's streams and register port, gives the verdict.
`timescale 1ns / 1ps
module stereo_mix_linear_resampler_test;
  import smlr_pkg::*;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int DIR_N           = 18;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr         = '0;
  logic [APB_DATA_W-1:0]  pwdata        = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int unsigned fail_count;
  int unsigned frames_pending;
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  logic        hold_start    = 1'b0;
  logic        hold_off      = 1'b0;
  int unsigned cycle_count   = 0;

  // Directed samples: full-scale corners, clipping both ways, odd mono values
  int dir_left[DIR_N]  = '{0, 131071, -131072, 131071, -131072, 100, 0, -131072, 131071,
                           32767, 32767, -32768, 1, 65535, 12345, -40000, 0, 20000};
  int dir_right[DIR_N] = '{0, 131071, -131072, -131072, 131071, -100, 0, 131071, -131072,
                           -32768, -32768, 32767, -1, -65535, -23456, 40000, 0, -20000};
  int dir_mono[DIR_N]  = '{0, 131071, -131072, 0, -1, -3, 3, 131071, -131072,
                           0, 1, -2, -131071, 65535, 777, -9, -131072, 20000};

  stereo_mix_linear_resampler #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  stereo_resample_checker #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) mix_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .mismatches_o(fail_count),
    .pending_o   (frames_pending)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stalls, or a forced hold-off
  always @(posedge clk_i) begin
    if (hold_off || ($urandom_range(99) < snk_stall_pct)) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
  end

  // Long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Random level with a random amplitude, so both clipping and clean frames occur
  function automatic int rand_level();
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom);
    return int'(v >>> $urandom_range(3, 0));
  endfunction

  // One input transaction, after a random gap
  task automatic push_sample(input int left, input int right, input int mono);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 3*IN_W){1'b0}}, IN_W'(mono), IN_W'(right), IN_W'(left)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Setup and access phase; psel and penable are dropped after the access before it returns
  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and let everything in flight come out; wait for a clock edge first so the
  // checker has counted the last input transaction
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (frames_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] step_word, input int src, input int snk,
                           input int count, input logic with_hold);
    apb_access(1'b1, REG_STEP_RATIO, step_word);
    apb_access(1'b0, REG_STEP_RATIO, '0);
    src_idle_pct  = src;
    snk_stall_pct = snk;
    if (with_hold) hold_start = 1'b1;
    repeat (count) push_sample(rand_level(), rand_level(), rand_level());
    settle();
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // Unmapped word must not disturb the reset step ratio
    apb_access(1'b1, REG_UNUSED, $urandom);
    apb_access(1'b0, REG_STEP_RATIO, '0);
    for (int i = 0; i < DIR_N; i++) push_sample(dir_left[i], dir_right[i], dir_mono[i]);
    settle();

    // Step ratios: max, min, exactly one (phase pins low), zero via masked upper bits
    run_phase(32'd262143, 0, 0, 100, 1'b0);
    run_phase(32'd65537, 51, 0, 100, 1'b0);
    run_phase(32'd65536, 0, 51, 40, 1'b0);
    run_phase(32'hFFFC_0000, 24, 24, 40, 1'b0);
    run_phase($urandom_range(262143, 65537), 24, 24, 120, 1'b0);
    run_phase(32'(STEP_RESET), 0, 0, 100, 1'b1);
    run_phase($urandom_range(262143, 65537), 51, 51, 100, 1'b0);

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/smlr_pkg.sv
rtl/core/smlr_cfg.sv
rtl/core/smlr_phase.sv
rtl/core/smlr_interp.sv
rtl/core/stereo_mix_linear_resampler.sv
bench/stereo_resample_checker.sv
bench/stereo_mix_linear_resampler_test.sv
